[src/ata_pio_host_sequencer_top_defines.svh]
// ----------------------------------------------------------------------------
// ATA PIO host sequencer assertion macros
// Shared clocked assertion forms; clk and rst_n must be visible at the use.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_HOST_SEQUENCER_TOP_DEFINES_SVH
`define ATA_PIO_HOST_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define APS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/aps_pkg.sv]
// ----------------------------------------------------------------------------
// ATA PIO host sequencer package
// Codes, task file constants and shared types of the sequencer.
// ----------------------------------------------------------------------------
package aps_pkg;

  // Input opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_IDENT = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  // Bus access kinds
  localparam logic [1:0] AK_NONE  = 2'd0;
  localparam logic [1:0] AK_WRITE = 2'd1;
  localparam logic [1:0] AK_RDBYTE = 2'd2;
  localparam logic [1:0] AK_RDWORD = 2'd3;

  // Completion codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_NO_DRIVE = 2'd1;
  localparam logic [1:0] ERR_NOT_ATA  = 2'd2;
  localparam logic [1:0] ERR_DEVICE   = 2'd3;

  // Task file offsets from base 0x1F0
  localparam logic [2:0] OFS_DATA   = 3'd0;
  localparam logic [2:0] OFS_COUNT  = 3'd2;
  localparam logic [2:0] OFS_LBA0   = 3'd3;
  localparam logic [2:0] OFS_LBA1   = 3'd4;
  localparam logic [2:0] OFS_LBA2   = 3'd5;
  localparam logic [2:0] OFS_DRIVE  = 3'd6;
  localparam logic [2:0] OFS_STATUS = 3'd7;

  // Status bits
  localparam int unsigned ST_BSY_BIT = 7;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_ERR_BIT = 0;

  // Drive select bases and commands
  localparam logic [7:0] DRV_LBA_BASE   = 8'hE0;
  localparam logic [7:0] DRV_IDENT_BASE = 8'hA0;
  localparam logic [7:0] CMD_READ       = 8'h20;
  localparam logic [7:0] CMD_IDENT      = 8'hEC;

  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);
  localparam logic [WORD_IDX_W-1:0] WORD_IDX_LAST = WORD_IDX_W'(WORDS_PER_SECTOR - 1);
  localparam logic [WORD_IDX_W-1:0] IDENT_TOT_LO  = WORD_IDX_W'(60);
  localparam logic [WORD_IDX_W-1:0] IDENT_TOT_HI  = WORD_IDX_W'(61);

  // Number of task file writes in a command burst
  localparam int unsigned CMD_WRITES = 6;
  localparam logic [2:0]  CMD_LAST_IDX = 3'(CMD_WRITES);

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_R_BSY_CMD = 13'b0000000000010,
    PH_DELAY     = 13'b0000000000100,
    PH_R_BSY     = 13'b0000000001000,
    PH_R_DRQ     = 13'b0000000010000,
    PH_R_WORDS   = 13'b0000000100000,
    PH_I_BSY_CMD = 13'b0000001000000,
    PH_I_STATUS  = 13'b0000010000000,
    PH_I_POLL    = 13'b0000100000000,
    PH_I_MID     = 13'b0001000000000,
    PH_I_HI      = 13'b0010000000000,
    PH_I_ERRCHK  = 13'b0100000000000,
    PH_I_WORDS   = 13'b1000000000000
  } phase_t;

  // Shape of the result burst caused by one transaction
  typedef enum logic [1:0] {
    M_NONE = 2'd0,  // no result
    M_ONE  = 2'd1,  // tail only
    M_WORD = 2'd2,  // delivered word, then tail
    M_CMD  = 2'd3   // six task file writes, then tail
  } mode_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [2:0]  port_offset;
    logic [7:0]  write_byte;
    logic        word_valid;
    logic [15:0] delivered_word;
    logic        finished;
    logic [1:0]  error_code;
    logic [31:0] sector_total;
  } res_t;

  typedef struct packed {
    mode_t                     mode;
    logic [CMD_WRITES-1:0][7:0] cmd_bytes;  // drive, count, lba0, lba1, lba2, cmd
    logic [15:0]               head_word;
    res_t                      tail;
  } burst_t;

  typedef struct packed {
    phase_t                phase;
    logic [27:0]           current_lba;
    logic [31:0]           sectors_left;
    logic [8:0]            chunk_left;
    logic [WORD_IDX_W-1:0] word_index;
    logic [2:0]            delay_left;
    logic [31:0]           captured_total;
    logic                  doing_identify;
  } seq_state_t;

  function automatic res_t res_status_read();
    res_t r;
    r = '0;
    r.access_kind = AK_RDBYTE;
    r.port_offset = OFS_STATUS;
    return r;
  endfunction

  function automatic res_t res_byte_read(input logic [2:0] ofs);
    res_t r;
    r = '0;
    r.access_kind = AK_RDBYTE;
    r.port_offset = ofs;
    return r;
  endfunction

  function automatic res_t res_word_read();
    res_t r;
    r = '0;
    r.access_kind = AK_RDWORD;
    r.port_offset = OFS_DATA;
    return r;
  endfunction

  function automatic res_t res_finish(input logic [1:0] err, input logic [31:0] tot);
    res_t r;
    r = '0;
    r.finished     = 1'b1;
    r.error_code   = err;
    r.sector_total = tot;
    return r;
  endfunction

  // Register offset of each write in a command burst
  function automatic logic [2:0] cmd_offset(input logic [2:0] idx);
    logic [2:0] o;
    case (idx)
      3'd0:    o = OFS_DRIVE;
      3'd1:    o = OFS_COUNT;
      3'd2:    o = OFS_LBA0;
      3'd3:    o = OFS_LBA1;
      3'd4:    o = OFS_LBA2;
      default: o = OFS_STATUS;
    endcase
    return o;
  endfunction

endpackage

[src/ata_pio_host_sequencer_top.sv]
// ----------------------------------------------------------------------------
// ATA PIO host sequencer, top level
// Drives LBA28 READ SECTORS and IDENTIFY DEVICE through the task file.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per command start (op 0 read, op 1 identify) or
//            per returned bus read (op 2, data in in_bus_data).
//   out_*  : one transaction per bus access to perform, per delivered data
//            word, or per end-of-command mark; out_last flags the final result
//            caused by an input transaction.
//   cfg_*  : writes select_slave (master/slave drive select); write it only
//            while the block is idle.
// Path: once accepted, an input transaction passes the input register, then
//   the result burst register, before its first result is presented.
// Throughput: one input transaction per cycle while each causes one result
//   and out_ready is high. An input that causes n results (1, 2, or 7 for a
//   command issue) holds the burst register until its final result is handed
//   out, and the next input is taken on that same cycle.
// Stall: while out_ready is low the burst and the input register hold; input
//   is refused once the input register is full.
// Reset: sequencer returns to idle, counters and the drive select clear, no
//   transaction is pending on either channel.
// ----------------------------------------------------------------------------
module ata_pio_host_sequencer_top #(
  parameter int unsigned MAX_CHUNK_SECTORS  = 256,
  parameter int unsigned DELAY_STATUS_READS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_select_slave,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [27:0] in_start_lba,
  input  logic [31:0] in_total_sectors,
  input  logic [15:0] in_bus_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_access_kind,
  output logic [2:0]  out_port_offset,
  output logic [7:0]  out_write_byte,
  output logic        out_word_valid,
  output logic [15:0] out_delivered_word,
  output logic        out_finished,
  output logic [1:0]  out_error_code,
  output logic [31:0] out_sector_total,
  output logic        out_last
);

  logic                select_slave_r;
  logic                in_full_r;
  logic                in_full_nxt;
  logic [1:0]          op_r;
  logic [27:0]         lba_r;
  logic [31:0]         total_r;
  logic [15:0]         data_r;
  aps_pkg::seq_state_t state_r;
  aps_pkg::seq_state_t state_nxt;
  aps_pkg::burst_t     burst;
  aps_pkg::res_t       res;
  logic                can_load;
  logic                load;
  logic                in_take;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_slave_r <= 1'b0;
    end else if (cfg_valid) begin
      select_slave_r <= cfg_select_slave;
    end
  end

  // Advance the held transaction into the step logic once the emitter frees
  assign load     = in_full_r && can_load;
  assign in_ready = !in_full_r || can_load;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (load) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_op;
      lba_r   <= in_start_lba;
      total_r <= in_total_sectors;
      data_r  <= in_bus_data;
    end
  end

  aps_step #(
    .MAX_CHUNK_SECTORS  (MAX_CHUNK_SECTORS),
    .DELAY_STATUS_READS (DELAY_STATUS_READS)
  ) u_step (
    .op            (op_r),
    .start_lba     (lba_r),
    .total_sectors (total_r),
    .bus_data      (data_r),
    .select_slave  (select_slave_r),
    .cur           (state_r),
    .nxt           (state_nxt),
    .burst         (burst)
  );

  // Commit the sequencer state only when the transaction is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aps_pkg::seq_state_t'{phase: aps_pkg::PH_IDLE, default: '0};
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

  aps_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_access_kind    = res.access_kind;
  assign out_port_offset    = res.port_offset;
  assign out_write_byte     = res.write_byte;
  assign out_word_valid     = res.word_valid;
  assign out_delivered_word = res.delivered_word;
  assign out_finished       = res.finished;
  assign out_error_code     = res.error_code;
  assign out_sector_total   = res.sector_total;

endmodule

[src/aps_step.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer step logic
// Next state and result burst for one transaction, from the current state.
// ----------------------------------------------------------------------------
module aps_step #(
  parameter int unsigned MAX_CHUNK_SECTORS  = 256,
  parameter int unsigned DELAY_STATUS_READS = 4
) (
  input  logic                [1:0]  op,
  input  logic                [27:0] start_lba,
  input  logic                [31:0] total_sectors,
  input  logic                [15:0] bus_data,
  input  logic                       select_slave,
  input  aps_pkg::seq_state_t        cur,
  output aps_pkg::seq_state_t        nxt,
  output aps_pkg::burst_t            burst
);

  localparam logic [8:0] MAX_CHUNK  = 9'(MAX_CHUNK_SECTORS);
  localparam logic [2:0] DELAY_INIT = 3'(DELAY_STATUS_READS - 1);
  localparam logic [aps_pkg::WORD_IDX_W-1:0] WORD_ONE =
    {{(aps_pkg::WORD_IDX_W-1){1'b0}}, 1'b1};

  logic [7:0]  st;
  logic [8:0]  chunk;
  logic [8:0]  chunk_dec;
  logic [31:0] tot_upd;
  logic [7:0]  drive_rd;
  logic [7:0]  drive_id;

  assign st       = bus_data[7:0];
  assign chunk    = (cur.sectors_left < 32'(MAX_CHUNK)) ? cur.sectors_left[8:0] : MAX_CHUNK;
  assign chunk_dec = (cur.chunk_left != 9'd0) ? cur.chunk_left - 9'd1 : 9'd0;
  assign drive_rd = aps_pkg::DRV_LBA_BASE | {3'd0, select_slave, cur.current_lba[27:24]};
  assign drive_id = aps_pkg::DRV_IDENT_BASE | {3'd0, select_slave, 4'd0};

  always_comb begin
    tot_upd = cur.captured_total;
    if (cur.word_index == aps_pkg::IDENT_TOT_LO) begin
      tot_upd = {cur.captured_total[31:16], bus_data};
    end else if (cur.word_index == aps_pkg::IDENT_TOT_HI) begin
      tot_upd = {bus_data, cur.captured_total[15:0]};
    end
  end

  always_comb begin
    nxt             = cur;
    burst           = '0;
    burst.mode      = aps_pkg::M_NONE;
    burst.head_word = bus_data;
    case (op)
      aps_pkg::OP_READ: begin
        nxt.current_lba    = start_lba;
        nxt.sectors_left   = total_sectors;
        nxt.chunk_left     = '0;
        nxt.word_index     = '0;
        nxt.doing_identify = 1'b0;
        burst.mode         = aps_pkg::M_ONE;
        if (total_sectors == 32'd0) begin
          nxt.phase  = aps_pkg::PH_IDLE;
          burst.tail = aps_pkg::res_finish(aps_pkg::ERR_OK, 32'd0);
        end else begin
          nxt.phase  = aps_pkg::PH_R_BSY_CMD;
          burst.tail = aps_pkg::res_status_read();
        end
      end
      aps_pkg::OP_IDENT: begin
        nxt.doing_identify = 1'b1;
        nxt.word_index     = '0;
        nxt.captured_total = '0;
        nxt.phase          = aps_pkg::PH_I_BSY_CMD;
        burst.mode         = aps_pkg::M_ONE;
        burst.tail         = aps_pkg::res_status_read();
      end
      aps_pkg::OP_DATA: begin
        if (cur.phase != aps_pkg::PH_IDLE) begin
          burst.mode = aps_pkg::M_ONE;
          burst.tail = aps_pkg::res_status_read();
          unique case (cur.phase)
            aps_pkg::PH_R_BSY_CMD: begin
              if (!st[aps_pkg::ST_BSY_BIT]) begin
                burst.mode      = aps_pkg::M_CMD;
                burst.cmd_bytes = {aps_pkg::CMD_READ, cur.current_lba[23:16],
                                   cur.current_lba[15:8], cur.current_lba[7:0],
                                   chunk[7:0], drive_rd};
                nxt.sectors_left = cur.sectors_left - 32'(chunk);
                nxt.current_lba  = cur.current_lba + 28'(chunk);
                nxt.chunk_left   = chunk;
                nxt.delay_left   = DELAY_INIT;
                nxt.phase        = aps_pkg::PH_DELAY;
              end
            end
            aps_pkg::PH_I_BSY_CMD: begin
              if (!st[aps_pkg::ST_BSY_BIT]) begin
                burst.mode      = aps_pkg::M_CMD;
                burst.cmd_bytes = {aps_pkg::CMD_IDENT, 8'd0, 8'd0, 8'd0, 8'd0, drive_id};
                nxt.delay_left  = DELAY_INIT;
                nxt.phase       = aps_pkg::PH_DELAY;
              end
            end
            aps_pkg::PH_DELAY: begin
              if (cur.delay_left != 3'd0) begin
                nxt.delay_left = cur.delay_left - 3'd1;
              end else if (cur.doing_identify) begin
                nxt.phase = aps_pkg::PH_I_STATUS;
              end else begin
                nxt.phase = aps_pkg::PH_R_BSY;
              end
            end
            aps_pkg::PH_R_BSY: begin
              if (!st[aps_pkg::ST_BSY_BIT]) begin
                nxt.phase = aps_pkg::PH_R_DRQ;
              end
            end
            aps_pkg::PH_R_DRQ: begin
              if (st[aps_pkg::ST_DRQ_BIT] || st[aps_pkg::ST_ERR_BIT]) begin
                nxt.phase      = aps_pkg::PH_R_WORDS;
                nxt.word_index = '0;
                burst.tail     = aps_pkg::res_word_read();
              end
            end
            aps_pkg::PH_R_WORDS: begin
              burst.mode = aps_pkg::M_WORD;
              if (cur.word_index != aps_pkg::WORD_IDX_LAST) begin
                nxt.word_index = cur.word_index + WORD_ONE;
                burst.tail     = aps_pkg::res_word_read();
              end else begin
                nxt.word_index = '0;
                nxt.chunk_left = chunk_dec;
                if (chunk_dec != 9'd0) begin
                  nxt.delay_left = DELAY_INIT;
                  nxt.phase      = aps_pkg::PH_DELAY;
                end else if (cur.sectors_left != 32'd0) begin
                  nxt.phase = aps_pkg::PH_R_BSY_CMD;
                end else begin
                  nxt.phase  = aps_pkg::PH_IDLE;
                  burst.tail = aps_pkg::res_finish(aps_pkg::ERR_OK, 32'd0);
                end
              end
            end
            aps_pkg::PH_I_STATUS: begin
              if (st == 8'd0) begin
                nxt.phase  = aps_pkg::PH_IDLE;
                burst.tail = aps_pkg::res_finish(aps_pkg::ERR_NO_DRIVE, 32'd0);
              end else begin
                nxt.phase = aps_pkg::PH_I_POLL;
              end
            end
            aps_pkg::PH_I_POLL: begin
              if (st[aps_pkg::ST_BSY_BIT]) begin
                nxt.phase  = aps_pkg::PH_I_MID;
                burst.tail = aps_pkg::res_byte_read(aps_pkg::OFS_LBA1);
              end else begin
                nxt.phase = aps_pkg::PH_I_ERRCHK;
              end
            end
            aps_pkg::PH_I_MID: begin
              if (st != 8'd0) begin
                nxt.phase  = aps_pkg::PH_IDLE;
                burst.tail = aps_pkg::res_finish(aps_pkg::ERR_NOT_ATA, 32'd0);
              end else begin
                nxt.phase  = aps_pkg::PH_I_HI;
                burst.tail = aps_pkg::res_byte_read(aps_pkg::OFS_LBA2);
              end
            end
            aps_pkg::PH_I_HI: begin
              if (st != 8'd0) begin
                nxt.phase  = aps_pkg::PH_IDLE;
                burst.tail = aps_pkg::res_finish(aps_pkg::ERR_NOT_ATA, 32'd0);
              end else begin
                nxt.phase = aps_pkg::PH_I_POLL;
              end
            end
            aps_pkg::PH_I_ERRCHK: begin
              if (st[aps_pkg::ST_ERR_BIT]) begin
                nxt.phase  = aps_pkg::PH_IDLE;
                burst.tail = aps_pkg::res_finish(aps_pkg::ERR_DEVICE, 32'd0);
              end else begin
                nxt.phase          = aps_pkg::PH_I_WORDS;
                nxt.word_index     = '0;
                nxt.captured_total = '0;
                burst.tail         = aps_pkg::res_word_read();
              end
            end
            aps_pkg::PH_I_WORDS: begin
              burst.mode         = aps_pkg::M_WORD;
              nxt.captured_total = tot_upd;
              if (cur.word_index != aps_pkg::WORD_IDX_LAST) begin
                nxt.word_index = cur.word_index + WORD_ONE;
                burst.tail     = aps_pkg::res_word_read();
              end else begin
                nxt.word_index = '0;
                nxt.phase      = aps_pkg::PH_IDLE;
                burst.tail     = aps_pkg::res_finish(aps_pkg::ERR_OK, tot_upd);
              end
            end
            default: begin
              nxt.phase  = aps_pkg::PH_IDLE;
              burst.mode = aps_pkg::M_NONE;
            end
          endcase
        end
      end
      default: begin
        burst.mode = aps_pkg::M_NONE;
      end
    endcase
  end

endmodule

[src/aps_emit.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer result emitter
// Holds one result burst and hands it out one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "ata_pio_host_sequencer_top_defines.svh"

module aps_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  aps_pkg::burst_t        burst,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output aps_pkg::res_t          out_res,
  output logic                   out_last
);

  logic                                    busy_r;
  logic                                    busy_nxt;
  logic [2:0]                              idx_r;
  logic [2:0]                              idx_nxt;
  aps_pkg::mode_t                          mode_r;
  logic [aps_pkg::CMD_WRITES-1:0][7:0]     bytes_r;
  logic [15:0]                             head_r;
  aps_pkg::res_t                           tail_r;
  logic                                    take;

  assign out_valid = busy_r;
  assign take      = busy_r && out_ready;
  assign can_load  = !busy_r || (out_ready && out_last);

  // Select the result at the current position of the burst
  always_comb begin
    out_res  = tail_r;
    out_last = 1'b1;
    case (mode_r)
      aps_pkg::M_CMD: begin
        out_last = (idx_r == aps_pkg::CMD_LAST_IDX);
        if (!out_last) begin
          out_res             = '0;
          out_res.access_kind = aps_pkg::AK_WRITE;
          out_res.port_offset = aps_pkg::cmd_offset(idx_r);
          out_res.write_byte  = bytes_r[idx_r];
        end
      end
      aps_pkg::M_WORD: begin
        out_last = (idx_r != 3'd0);
        if (!out_last) begin
          out_res                = '0;
          out_res.word_valid     = 1'b1;
          out_res.delivered_word = head_r;
        end
      end
      default: begin
        out_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = (burst.mode != aps_pkg::M_NONE);
      idx_nxt  = '0;
    end else if (take) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      mode_r <= aps_pkg::M_NONE;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (load) begin
        mode_r <= burst.mode;
      end
    end
  end

  // Burst payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.cmd_bytes;
      head_r  <= burst.head_word;
      tail_r  <= burst.tail;
    end
  end

  `APS_ASSERT_IMPL(a_load_when_free, load, can_load, "burst loaded over a pending result")
  `APS_ASSERT_IMPL(a_busy_has_burst, busy_r, mode_r != aps_pkg::M_NONE, "busy with empty burst")
  `APS_ASSERT_IMPL(a_word_idx_range, busy_r && (mode_r == aps_pkg::M_WORD), idx_r <= 3'd1, "word burst index overrun")
  `APS_ASSERT_NEXT(a_stall_holds_pos, busy_r && !out_ready && !load, busy_r && $stable(idx_r), "stalled burst moved")

endmodule
